// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Clocked on clk; the first form is held off during reset, the second is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define ASSERT_CLK_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/biq_pkg.sv -----
// ----------------------------------------------------------------------------
// biq_pkg
// Shared widths, register codes and types of the six-channel biquad filter.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int NUM_CH        = 6;
  localparam int SAMPLE_W      = 24;
  localparam int COEF_W        = 32;
  localparam int COEF_FRAC_DEF = 30;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEED0  = 3'd0,
    REG_FEED1  = 3'd1,
    REG_FEED2  = 3'd2,
    REG_BACK1  = 3'd3,
    REG_BACK2  = 3'd4,
    REG_ENABLE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    coef_t feed0;
    coef_t feed1;
    coef_t feed2;
    coef_t back1;
    coef_t back2;
  } biq_coef_t;

  typedef struct packed {
    logic load;
    logic commit;
  } biq_ctrl_t;

endpackage

// ----- rtl/core/biq_if.sv -----
// ----------------------------------------------------------------------------
// biq_if
// Valid/ready channels: six raw samples in, six filtered values and ok out.
// ----------------------------------------------------------------------------
interface biq_sample_if
  import biq_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t sample_0;
  sample_t sample_1;
  sample_t sample_2;
  sample_t sample_3;
  sample_t sample_4;
  sample_t sample_5;

  modport source (output valid, output sample_0, output sample_1, output sample_2,
                  output sample_3, output sample_4, output sample_5, input ready);
  modport sink   (input valid, input sample_0, input sample_1, input sample_2,
                  input sample_3, input sample_4, input sample_5, output ready);
endinterface

interface biq_result_if
  import biq_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t filtered_0;
  sample_t filtered_1;
  sample_t filtered_2;
  sample_t filtered_3;
  sample_t filtered_4;
  sample_t filtered_5;
  logic    ok;

  modport source (output valid, output filtered_0, output filtered_1, output filtered_2,
                  output filtered_3, output filtered_4, output filtered_5, output ok,
                  input ready);
  modport sink   (input valid, input filtered_0, input filtered_1, input filtered_2,
                  input filtered_3, input filtered_4, input filtered_5, input ok,
                  output ready);
endinterface

// ----- rtl/core/biq_lane.sv -----
// ----------------------------------------------------------------------------
// biq_lane
// One channel of the direct form I biquad: five registered products, then
// sum, round half up, scale and saturate; holds the channel's delay line.
// ----------------------------------------------------------------------------
module biq_lane
  import biq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  biq_coef_t coef,
  input  biq_ctrl_t ctrl,
  input  sample_t   sample,
  output sample_t   result
);

  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 3;

  localparam logic signed [ACC_W-1:0] ROUND   = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  sample_t x_hold;
  sample_t x_one;
  sample_t x_two;
  sample_t y_one;
  sample_t y_two;

  logic signed [PROD_W-1:0] prod_f0;
  logic signed [PROD_W-1:0] prod_f1;
  logic signed [PROD_W-1:0] prod_f2;
  logic signed [PROD_W-1:0] prod_b1;
  logic signed [PROD_W-1:0] prod_b2;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] scaled;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_hold  <= sample;
      prod_f0 <= PROD_W'(coef.feed0) * PROD_W'(sample);
      prod_f1 <= PROD_W'(coef.feed1) * PROD_W'(x_one);
      prod_f2 <= PROD_W'(coef.feed2) * PROD_W'(x_two);
      prod_b1 <= PROD_W'(coef.back1) * PROD_W'(y_one);
      prod_b2 <= PROD_W'(coef.back2) * PROD_W'(y_two);
    end
  end

  always_comb begin
    acc = ACC_W'(prod_f0) + ACC_W'(prod_f1) + ACC_W'(prod_f2)
        - ACC_W'(prod_b1) - ACC_W'(prod_b2) + ROUND;
    scaled = acc >>> COEF_FRAC_BITS;
    if (scaled > SAT_MAX) begin
      result = SAT_MAX[SAMPLE_W-1:0];
    end else if (scaled < SAT_MIN) begin
      result = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      result = scaled[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_one <= '0;
      x_two <= '0;
      y_one <= '0;
      y_two <= '0;
    end else if (ctrl.commit) begin
      x_one <= x_hold;
      x_two <= x_one;
      y_one <= result;
      y_two <= y_one;
    end
  end

endmodule

// ----- rtl/core/multichannel_biquad_lowpass.sv -----
// ----------------------------------------------------------------------------
// multichannel_biquad_lowpass
// Six independent second-order low-pass filters (direct form I) run in six
// parallel lanes on the six samples of each request. Each lane registers its
// five products at the edge that takes the request; from them it sums, rounds
// half up, scales by 2^COEF_FRAC_BITS and saturates to 24 bits, and the output
// register takes that value once free; the saturated value feeds back. A new
// request waits until the last has moved on into the output register, as the
// feedback loop through the lane multipliers and the adder spans two registers.
// An output register holds a finished result, so the next request is taken
// while it waits. Host-written coefficients are Q2.30 by default (COEF_W bits,
// COEF_FRAC_BITS fraction bits); with the filter disabled a request returns
// zeros with ok low and leaves the filter state untouched.
// ----------------------------------------------------------------------------
module multichannel_biquad_lowpass
  import biq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  biq_sample_if.sink           samples,
  biq_result_if.source         filtered
);

  biq_coef_t coef;
  logic      filter_enable;

  logic      p_valid;
  logic      p_en;
  logic      out_valid;
  logic      out_ok;
  sample_t   out_data [NUM_CH];

  sample_t   lane_in  [NUM_CH];
  sample_t   lane_out [NUM_CH];

  logic      accept;
  logic      out_free;
  logic      p_adv;
  biq_ctrl_t ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef          <= '0;
      filter_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FEED0:  coef.feed0    <= cfg_data[COEF_W-1:0];
        REG_FEED1:  coef.feed1    <= cfg_data[COEF_W-1:0];
        REG_FEED2:  coef.feed2    <= cfg_data[COEF_W-1:0];
        REG_BACK1:  coef.back1    <= cfg_data[COEF_W-1:0];
        REG_BACK2:  coef.back2    <= cfg_data[COEF_W-1:0];
        REG_ENABLE: filter_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign lane_in[0] = samples.sample_0;
  assign lane_in[1] = samples.sample_1;
  assign lane_in[2] = samples.sample_2;
  assign lane_in[3] = samples.sample_3;
  assign lane_in[4] = samples.sample_4;
  assign lane_in[5] = samples.sample_5;

  assign samples.ready = !p_valid;
  assign accept        = samples.valid && !p_valid;
  assign out_free      = !out_valid || filtered.ready;
  assign p_adv         = p_valid && out_free;

  assign ctrl.load   = accept;
  assign ctrl.commit = p_adv && p_en;

  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    biq_lane #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .coef   (coef),
      .ctrl   (ctrl),
      .sample (lane_in[i]),
      .result (lane_out[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (p_adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_en <= filter_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_adv) begin
      out_valid <= 1'b1;
    end else if (filtered.ready) begin
      out_valid <= 1'b0;
    end
  end

  // merge the lanes; force zeros when disabled
  always_ff @(posedge clk) begin
    if (p_adv) begin
      out_ok <= p_en;
      for (int i = 0; i < NUM_CH; i++) begin
        out_data[i] <= p_en ? lane_out[i] : '0;
      end
    end
  end

  assign filtered.valid      = out_valid;
  assign filtered.ok         = out_ok;
  assign filtered.filtered_0 = out_data[0];
  assign filtered.filtered_1 = out_data[1];
  assign filtered.filtered_2 = out_data[2];
  assign filtered.filtered_3 = out_data[3];
  assign filtered.filtered_4 = out_data[4];
  assign filtered.filtered_5 = out_data[5];

endmodule

// ----- rtl/core/biq_checker.sv -----
// ----------------------------------------------------------------------------
// biq_checker
// Port-level checks of request spacing, result timing, the disabled case, output hold and reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module biq_checker
  import biq_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input logic    out_ok,
  input sample_t filtered_0,
  input sample_t filtered_1,
  input sample_t filtered_2,
  input sample_t filtered_3,
  input sample_t filtered_4,
  input sample_t filtered_5
);

  `ASSERT_CLK(a_spacing, (in_valid && in_ready) |=> !in_ready)
  `ASSERT_CLK(a_latency, (in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
  `ASSERT_CLK(a_disabled_zero, (out_valid && !out_ok) |-> (filtered_0 == '0 && filtered_1 == '0 && filtered_2 == '0 && filtered_3 == '0 && filtered_4 == '0 && filtered_5 == '0))
  `ASSERT_CLK(a_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_ok) && $stable(filtered_0)))
  `ASSERT_CLK_RST(a_reset, $past(rst) |-> !out_valid)

endmodule

bind multichannel_biquad_lowpass biq_checker u_biq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (filtered.valid),
  .out_ready  (filtered.ready),
  .out_ok     (filtered.ok),
  .filtered_0 (filtered.filtered_0),
  .filtered_1 (filtered.filtered_1),
  .filtered_2 (filtered.filtered_2),
  .filtered_3 (filtered.filtered_3),
  .filtered_4 (filtered.filtered_4),
  .filtered_5 (filtered.filtered_5)
);
